### sv/tbec_pkg.sv
// shared types, constants and helper functions for the collision block
package tbec_pkg;

  localparam int unsigned IDX_W              = 10;
  localparam int unsigned VAL_W              = 32;
  localparam int unsigned ALU_W              = 64;
  localparam int unsigned PARTICLE_COUNT_DEF = 1024;
  localparam int unsigned S_TDATA_W          = 248;
  localparam int unsigned M_TDATA_W          = 112;
  localparam logic [31:0] DENSITY_RST        = 32'h0001_0000;

  // normal component magnitudes and weights are unsigned q1.28
  localparam int unsigned FRAC_N = 28;

  // iteration counts of the shared unit
  localparam int unsigned MUL_STEPS  = 32;
  localparam int unsigned DIV_STEPS  = 64;
  localparam int unsigned SQRT_STEPS = 32;
  localparam logic [ALU_W-1:0] SQRT_TOP = 64'h4000_0000_0000_0000;

  // request kinds on the input stream
  localparam logic REQ_LOAD    = 1'b0;
  localparam logic REQ_COLLIDE = 1'b1;

  typedef enum logic [2:0] {
    ALU_MUL  = 3'b001,
    ALU_DIV  = 3'b010,
    ALU_SQRT = 3'b100
  } alu_op_e;

  typedef struct packed {
    logic    start;
    alu_op_e op;
  } alu_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } alu_rsp_t;

  // round to nearest, ties away from zero, by 2^28
  function automatic logic signed [63:0] round_q28(input logic signed [63:0] x);
    logic signed [63:0] half;
    half = 64'sd1 <<< (FRAC_N - 1);
    return (x + (x[63] ? half - 64'sd1 : half)) >>> FRAC_N;
  endfunction

  // turn a magnitude into a two's complement value
  function automatic logic signed [63:0] apply_sign(input logic [63:0] m, input logic neg);
    return $signed((m ^ {64{neg}}) + 64'(neg));
  endfunction

  function automatic logic [63:0] abs64(input logic signed [63:0] x);
    return x[63] ? 64'(-x) : 64'(x);
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    logic signed [31:0] res;
    if (x > 64'sh0000_0000_7FFF_FFFF) begin
      res = 32'sh7FFF_FFFF;
    end else if (x < -64'sh0000_0000_8000_0000) begin
      res = 32'sh8000_0000;
    end else begin
      res = x[31:0];
    end
    return res;
  endfunction

endpackage

### sv/two_body_elastic_collision.sv
// top level: particle table, collision sequencer and stream ports
// a load passes through the 10 index-wrap steps and a table write before it is ready again
// a collision reads both entries, then runs the serial unit; a degenerate one skips to the output
// one item at a time: the serial unit (32-step multiply, 64-step divide, 32-step root)
// runs 19 multiplies, 5 divides and 1 root per non-degenerate collision
// reset: sequencer, handshakes and density (1.0) cleared asynchronously; table not cleared
module two_body_elastic_collision #(
  parameter int unsigned PARTICLE_COUNT = tbec_pkg::PARTICLE_COUNT_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // index_a, index_b, load_pos_x, load_pos_y, load_pos_z, load_vel_u, load_vel_v,
  // load_vel_w, load_volume, zero pad
  input  logic [tbec_pkg::S_TDATA_W-1:0]    s_axis_tdata,
  input  logic [0:0]                        s_axis_tuser,   // req_type
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // particle_index, new_vel_u, new_vel_v, new_vel_w, zero pad
  output logic [tbec_pkg::M_TDATA_W-1:0]    m_axis_tdata,
  output logic [0:0]                        m_axis_tuser,   // degenerate
  output logic                              m_axis_tlast,   // last_of_pair
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  input  logic                              cfg_we_i,
  input  logic [31:0]                       cfg_wdata_i
);

  localparam int unsigned AW = (PARTICLE_COUNT > 1) ? $clog2(PARTICLE_COUNT) : 1;

  typedef enum logic [24:0] {
    ST_IDLE  = 25'h0000001,
    ST_WRAP  = 25'h0000002,
    ST_LOAD  = 25'h0000004,
    ST_RDA   = 25'h0000008,
    ST_RDB   = 25'h0000010,
    ST_CAPB  = 25'h0000020,
    ST_MASS  = 25'h0000040,
    ST_CHECK = 25'h0000080,
    ST_NORM  = 25'h0000100,
    ST_SQSUM = 25'h0000200,
    ST_SQRT  = 25'h0000400,
    ST_NDIV  = 25'h0000800,
    ST_VN    = 25'h0001000,
    ST_RNDVN = 25'h0002000,
    ST_MNORM = 25'h0004000,
    ST_WDIV  = 25'h0008000,
    ST_DMUL  = 25'h0010000,
    ST_DRND  = 25'h0020000,
    ST_VMUL  = 25'h0040000,
    ST_VRND  = 25'h0080000,
    ST_VADD  = 25'h0100000,
    ST_WRA   = 25'h0200000,
    ST_WRB   = 25'h0400000,
    ST_OUTA  = 25'h0800000,
    ST_OUTB  = 25'h1000000
  } state_e;

  localparam logic [2:0] LAST2 = 3'd1;
  localparam logic [2:0] LAST3 = 3'd2;
  localparam logic [2:0] LAST6 = 3'd5;

  state_e state_q, state_d;
  logic       issued_q;
  logic [2:0] j_q;
  logic [3:0] wk_q;
  logic       req_q;
  logic [31:0] density_q;

  logic [tbec_pkg::IDX_W-1:0] ia_q, ib_q;
  logic [AW-1:0] ia_addr, ib_addr, mem_raddr, mem_waddr;

  // table
  logic [31:0] pos_x_mem [0:PARTICLE_COUNT-1];
  logic [31:0] pos_y_mem [0:PARTICLE_COUNT-1];
  logic [31:0] pos_z_mem [0:PARTICLE_COUNT-1];
  logic [31:0] vel_u_mem [0:PARTICLE_COUNT-1];
  logic [31:0] vel_v_mem [0:PARTICLE_COUNT-1];
  logic [31:0] vel_w_mem [0:PARTICLE_COUNT-1];
  logic [31:0] volume_mem [0:PARTICLE_COUNT-1];
  logic signed [31:0] rd_pos_q [3];
  logic signed [31:0] rd_vel_q [3];
  logic [31:0] rd_vol_q;
  logic pos_we, vel_we;
  logic signed [31:0] wr_vel [3];

  // working registers
  logic signed [31:0] pa_q [3];
  logic signed [31:0] va_q [3];
  logic signed [31:0] vb_q [3];
  logic [31:0] vola_q, volb_q;
  logic [32:0] mag_q [3];
  logic        dneg_q [3];
  logic [63:0] ma_q, mb_q, sum_q;
  logic [31:0] r_q;
  logic [28:0] n_q [3];
  logic [28:0] wa_q, wb_q;
  logic signed [63:0] vna_q, vnb_q, diff_q, da_q, db_q, t_q;
  logic deg_q;

  // shared unit hookup
  tbec_pkg::alu_req_t alu_req;
  tbec_pkg::alu_rsp_t alu_rsp;
  logic [63:0] alu_opa, alu_opb, alu_res;
  logic alu_state, alu_done;

  logic s_accept, m_accept;
  logic [1:0] jj;
  logic side;
  logic signed [31:0] vel_sel;
  logic signed [63:0] d_sel, vel_sum;
  logic mag_hi, mag_b30, mag_zero, mass_hi;
  logic [26:0] wrap_sub;

  assign s_accept = s_axis_tvalid && s_axis_tready;
  assign m_accept = m_axis_tvalid && m_axis_tready;

  assign side    = j_q >= 3'd3;
  assign jj      = side ? 2'(j_q - 3'd3) : j_q[1:0];
  assign vel_sel = side ? vb_q[jj] : va_q[jj];
  assign d_sel   = side ? db_q : da_q;
  assign vel_sum = 64'(vel_sel) + t_q;

  assign ia_addr = AW'(ia_q);
  assign ib_addr = AW'(ib_q);

  assign mag_hi   = |{mag_q[0][32:31], mag_q[1][32:31], mag_q[2][32:31]};
  assign mag_b30  = mag_q[0][30] | mag_q[1][30] | mag_q[2][30];
  assign mag_zero = (mag_q[0] == '0) && (mag_q[1] == '0) && (mag_q[2] == '0);
  assign mass_hi  = |((ma_q | mb_q) >> 31);
  assign wrap_sub = 27'(PARTICLE_COUNT) << wk_q;

  // density register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      density_q <= tbec_pkg::DENSITY_RST;
    end else if (cfg_we_i) begin
      density_q <= cfg_wdata_i;
    end
  end

  // table ports
  assign pos_we    = (state_q == ST_LOAD);
  assign vel_we    = (state_q == ST_LOAD) || (state_q == ST_WRA) || (state_q == ST_WRB);
  assign mem_raddr = (state_q == ST_RDA) ? ia_addr : ib_addr;
  assign mem_waddr = (state_q == ST_WRB) ? ib_addr : ia_addr;
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      wr_vel[i] = (state_q == ST_WRB) ? vb_q[i] : va_q[i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pos_we) begin
      pos_x_mem[mem_waddr]  <= pa_q[0];
      pos_y_mem[mem_waddr]  <= pa_q[1];
      pos_z_mem[mem_waddr]  <= pa_q[2];
      volume_mem[mem_waddr] <= vola_q;
    end
    if (vel_we) begin
      vel_u_mem[mem_waddr] <= wr_vel[0];
      vel_v_mem[mem_waddr] <= wr_vel[1];
      vel_w_mem[mem_waddr] <= wr_vel[2];
    end
    rd_pos_q[0] <= pos_x_mem[mem_raddr];
    rd_pos_q[1] <= pos_y_mem[mem_raddr];
    rd_pos_q[2] <= pos_z_mem[mem_raddr];
    rd_vel_q[0] <= vel_u_mem[mem_raddr];
    rd_vel_q[1] <= vel_v_mem[mem_raddr];
    rd_vel_q[2] <= vel_w_mem[mem_raddr];
    rd_vol_q    <= volume_mem[mem_raddr];
  end

  // operands for the shared unit
  always_comb begin
    alu_state = 1'b1;
    alu_req.op = tbec_pkg::ALU_MUL;
    alu_opa = '0;
    alu_opb = '0;
    unique case (state_q)
      ST_MASS: begin
        alu_opa = 64'(density_q);
        alu_opb = 64'(j_q[0] ? volb_q : vola_q);
      end
      ST_SQSUM: begin
        alu_opa = 64'(mag_q[jj]);
        alu_opb = 64'(mag_q[jj]);
      end
      ST_SQRT: begin
        alu_req.op = tbec_pkg::ALU_SQRT;
        alu_opa = sum_q;
      end
      ST_NDIV: begin
        alu_req.op = tbec_pkg::ALU_DIV;
        alu_opa = (64'(mag_q[jj]) << tbec_pkg::FRAC_N) + 64'(r_q >> 1);
        alu_opb = 64'(r_q);
      end
      ST_VN: begin
        alu_opa = tbec_pkg::abs64(64'(vel_sel));
        alu_opb = 64'(n_q[jj]);
      end
      ST_WDIV: begin
        alu_req.op = tbec_pkg::ALU_DIV;
        alu_opa = (j_q[0] ? mb_q : ma_q) << tbec_pkg::FRAC_N;
        alu_opb = ma_q + mb_q;
      end
      ST_DMUL: begin
        alu_opa = tbec_pkg::abs64(diff_q);
        alu_opb = 64'(j_q[0] ? wa_q : wb_q);
      end
      ST_VMUL: begin
        alu_opa = tbec_pkg::abs64(d_sel);
        alu_opb = 64'(n_q[jj]);
      end
      default: alu_state = 1'b0;
    endcase
    alu_req.start = alu_state && !issued_q;
  end

  assign alu_done = alu_rsp.done;

  tbec_alu u_alu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (alu_req),
    .opa_i  (alu_opa),
    .opb_i  (alu_opb),
    .rsp_o  (alu_rsp),
    .res_o  (alu_res)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (s_accept) state_d = ST_WRAP;
      ST_WRAP:  if (wk_q == 4'd0) state_d = (req_q == tbec_pkg::REQ_COLLIDE) ? ST_RDA : ST_LOAD;
      ST_LOAD:  state_d = ST_IDLE;
      ST_RDA:   state_d = ST_RDB;
      ST_RDB:   state_d = ST_CAPB;
      ST_CAPB:  state_d = ST_MASS;
      ST_MASS:  if (alu_done && j_q == LAST2) state_d = ST_CHECK;
      ST_CHECK: state_d = (mag_zero || (ma_q == '0 && mb_q == '0)) ? ST_OUTA : ST_NORM;
      ST_NORM:  if (!mag_hi && mag_b30) state_d = ST_SQSUM;
      ST_SQSUM: if (alu_done && j_q == LAST3) state_d = ST_SQRT;
      ST_SQRT:  if (alu_done) state_d = ST_NDIV;
      ST_NDIV:  if (alu_done && j_q == LAST3) state_d = ST_VN;
      ST_VN:    if (alu_done && j_q == LAST6) state_d = ST_RNDVN;
      ST_RNDVN: state_d = ST_MNORM;
      ST_MNORM: if (!mass_hi) state_d = ST_WDIV;
      ST_WDIV:  if (alu_done && j_q == LAST2) state_d = ST_DMUL;
      ST_DMUL:  if (alu_done && j_q == LAST2) state_d = ST_DRND;
      ST_DRND:  state_d = ST_VMUL;
      ST_VMUL:  if (alu_done) state_d = ST_VRND;
      ST_VRND:  state_d = ST_VADD;
      ST_VADD:  state_d = (j_q == LAST6) ? ST_WRA : ST_VMUL;
      ST_WRA:   state_d = ST_WRB;
      ST_WRB:   state_d = ST_OUTA;
      ST_OUTA:  if (m_axis_tready) state_d = ST_OUTB;
      ST_OUTB:  if (m_axis_tready) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // sequencer control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      issued_q <= 1'b0;
      j_q      <= '0;
      wk_q     <= '0;
    end else begin
      state_q <= state_d;
      if (alu_req.start) begin
        issued_q <= 1'b1;
      end else if (alu_done) begin
        issued_q <= 1'b0;
      end
      if (s_accept) begin
        wk_q <= 4'(tbec_pkg::IDX_W - 1);
      end else if (state_q == ST_WRAP && wk_q != 4'd0) begin
        wk_q <= wk_q - 4'd1;
      end
      // step index within a multi-step phase
      if (state_q == ST_VADD) begin
        j_q <= (j_q == LAST6) ? 3'd0 : j_q + 3'd1;
      end else if (alu_done && alu_state && state_q != ST_VMUL) begin
        if (state_d != state_q) begin
          j_q <= '0;
        end else begin
          j_q <= j_q + 3'd1;
        end
      end
    end
  end

  // working datapath
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        if (s_accept) begin
          req_q     <= s_axis_tuser[0];
          ia_q      <= s_axis_tdata[9:0];
          ib_q      <= s_axis_tdata[19:10];
          pa_q[0]   <= s_axis_tdata[51:20];
          pa_q[1]   <= s_axis_tdata[83:52];
          pa_q[2]   <= s_axis_tdata[115:84];
          va_q[0]   <= s_axis_tdata[147:116];
          va_q[1]   <= s_axis_tdata[179:148];
          va_q[2]   <= s_axis_tdata[211:180];
          vola_q    <= s_axis_tdata[243:212];
        end
      end
      ST_WRAP: begin
        if ({17'b0, ia_q} >= wrap_sub) ia_q <= ia_q - wrap_sub[9:0];
        if ({17'b0, ib_q} >= wrap_sub) ib_q <= ib_q - wrap_sub[9:0];
      end
      ST_RDB: begin
        for (int i = 0; i < 3; i++) begin
          pa_q[i] <= rd_pos_q[i];
          va_q[i] <= rd_vel_q[i];
        end
        vola_q <= rd_vol_q;
      end
      ST_CAPB: begin
        for (int i = 0; i < 3; i++) begin
          vb_q[i]   <= rd_vel_q[i];
          dneg_q[i] <= pa_q[i] < rd_pos_q[i];
          mag_q[i]  <= (pa_q[i] < rd_pos_q[i]) ? 33'(33'(rd_pos_q[i]) - 33'(pa_q[i]))
                                               : 33'(33'(pa_q[i]) - 33'(rd_pos_q[i]));
        end
        volb_q <= rd_vol_q;
      end
      ST_MASS: begin
        if (alu_done) begin
          if (j_q[0]) mb_q <= alu_res;
          else        ma_q <= alu_res;
        end
      end
      ST_CHECK: begin
        deg_q <= mag_zero || (ma_q == '0 && mb_q == '0);
        sum_q <= '0;
      end
      ST_NORM: begin
        for (int i = 0; i < 3; i++) begin
          if (mag_hi)        mag_q[i] <= mag_q[i] >> 1;
          else if (!mag_b30) mag_q[i] <= mag_q[i] << 1;
        end
      end
      ST_SQSUM: if (alu_done) sum_q <= sum_q + alu_res;
      ST_SQRT: begin
        if (alu_done) begin
          r_q   <= alu_res[31:0];
          vna_q <= '0;
          vnb_q <= '0;
        end
      end
      ST_NDIV: if (alu_done) n_q[jj] <= alu_res[28:0];
      ST_VN: begin
        if (alu_done) begin
          if (side) vnb_q <= vnb_q + tbec_pkg::apply_sign(alu_res, vel_sel[31] ^ dneg_q[jj]);
          else      vna_q <= vna_q + tbec_pkg::apply_sign(alu_res, vel_sel[31] ^ dneg_q[jj]);
        end
      end
      ST_RNDVN: begin
        vna_q <= tbec_pkg::round_q28(vna_q);
        vnb_q <= tbec_pkg::round_q28(vnb_q);
      end
      ST_MNORM: begin
        diff_q <= vnb_q - vna_q;
        if (mass_hi) begin
          ma_q <= ma_q >> 1;
          mb_q <= mb_q >> 1;
        end
      end
      ST_WDIV: begin
        if (alu_done) begin
          if (j_q[0]) wb_q <= alu_res[28:0];
          else        wa_q <= alu_res[28:0];
        end
      end
      ST_DMUL: begin
        // 2*wb*diff for a, -2*wa*diff for b
        if (alu_done) begin
          if (j_q[0]) db_q <= tbec_pkg::apply_sign(alu_res << 1, !diff_q[63]);
          else        da_q <= tbec_pkg::apply_sign(alu_res << 1, diff_q[63]);
        end
      end
      ST_DRND: begin
        da_q <= tbec_pkg::round_q28(da_q);
        db_q <= tbec_pkg::round_q28(db_q);
      end
      ST_VMUL: if (alu_done) t_q <= tbec_pkg::apply_sign(alu_res, d_sel[63] ^ dneg_q[jj]);
      ST_VRND: t_q <= tbec_pkg::round_q28(t_q);
      ST_VADD: begin
        if (side) vb_q[jj] <= tbec_pkg::sat32(vel_sum);
        else      va_q[jj] <= tbec_pkg::sat32(vel_sum);
      end
      default: deg_q <= deg_q;
    endcase
  end

  // stream outputs
  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = (state_q == ST_OUTA) || (state_q == ST_OUTB);
  assign m_axis_tlast  = (state_q == ST_OUTB);
  assign m_axis_tuser  = deg_q;
  assign m_axis_tdata  = m_axis_tlast
                         ? {6'b0, vb_q[2], vb_q[1], vb_q[0], ib_q}
                         : {6'b0, va_q[2], va_q[1], va_q[0], ia_q};

  // checks
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid))
    else $error("input taken while a result is pending");

  a_pair_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_accept && !m_axis_tlast) |=> (m_axis_tvalid && m_axis_tlast))
    else $error("result b does not follow result a");

  a_alu_idle_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    alu_req.start |-> !alu_rsp.busy)
    else $error("shared unit started while busy");

  a_no_degen_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_WRA) || (state_q == ST_WRB)) |-> !deg_q)
    else $error("velocity written back on a degenerate collision");

endmodule

### sv/tbec_alu.sv
// iterative shared unit: shift-add multiply, restoring divide, integer square root
module tbec_alu (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  tbec_pkg::alu_req_t            req_i,
  input  logic [tbec_pkg::ALU_W-1:0]    opa_i,
  input  logic [tbec_pkg::ALU_W-1:0]    opb_i,
  output tbec_pkg::alu_rsp_t            rsp_o,
  output logic [tbec_pkg::ALU_W-1:0]    res_o
);

  tbec_pkg::alu_op_e op_q;
  logic       busy_q, done_q;
  logic [5:0] cnt_q;
  logic [63:0] x_q, y_q;
  logic [64:0] acc_q;

  logic [64:0] mul_sum, div_sh, div_diff;
  logic        div_ge, sq_ge;
  logic [63:0] sq_t;
  logic        start;

  assign start = req_i.start && !busy_q;

  // one step of each operation
  assign mul_sum  = acc_q + {1'b0, x_q};
  assign div_sh   = {acc_q[63:0], x_q[63]};
  assign div_ge   = div_sh >= {1'b0, y_q};
  assign div_diff = div_sh - {1'b0, y_q};
  assign sq_t     = acc_q[63:0] + y_q;
  assign sq_ge    = x_q >= sq_t;

  // step counter and handshake
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q   <= tbec_pkg::ALU_MUL;
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start) begin
        busy_q <= 1'b1;
        op_q   <= req_i.op;
        unique case (req_i.op)
          tbec_pkg::ALU_MUL:  cnt_q <= 6'(tbec_pkg::MUL_STEPS - 1);
          tbec_pkg::ALU_DIV:  cnt_q <= 6'(tbec_pkg::DIV_STEPS - 1);
          tbec_pkg::ALU_SQRT: cnt_q <= 6'(tbec_pkg::SQRT_STEPS - 1);
          default:            cnt_q <= 6'(tbec_pkg::DIV_STEPS - 1);
        endcase
      end else if (busy_q) begin
        cnt_q <= cnt_q - 6'd1;
        if (cnt_q == 6'd0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (start) begin
      x_q   <= opa_i;
      y_q   <= (req_i.op == tbec_pkg::ALU_SQRT) ? tbec_pkg::SQRT_TOP : opb_i;
      acc_q <= '0;
    end else if (busy_q) begin
      unique case (op_q)
        tbec_pkg::ALU_MUL: begin
          if (y_q[0]) acc_q <= {1'b0, mul_sum[63:0]};
          x_q <= x_q << 1;
          y_q <= y_q >> 1;
        end
        tbec_pkg::ALU_DIV: begin
          acc_q <= div_ge ? div_diff : div_sh;
          x_q   <= {x_q[62:0], div_ge};
        end
        tbec_pkg::ALU_SQRT: begin
          if (sq_ge) begin
            x_q   <= x_q - sq_t;
            acc_q <= {1'b0, (acc_q[63:0] >> 1) + y_q};
          end else begin
            acc_q <= {1'b0, acc_q[63:0] >> 1};
          end
          y_q <= y_q >> 2;
        end
        default: x_q <= x_q;
      endcase
    end
  end

  // result select
  always_comb begin
    unique case (op_q)
      tbec_pkg::ALU_MUL:  res_o = acc_q[63:0];
      tbec_pkg::ALU_DIV:  res_o = x_q;
      tbec_pkg::ALU_SQRT: res_o = acc_q[63:0];
      default:            res_o = x_q;
    endcase
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;

endmodule

### tb/two_body_elastic_collision_tb.sv
// self-checking testbench for the two-body elastic collision block
`timescale 1ns / 1ps

module two_body_elastic_collision_tb;

  localparam int          N_DIRECTED = 15;
  localparam int          N_RANDOM   = 1150;
  localparam int          N_PHASES   = 5;
  localparam int          CYC_LIMIT  = 4000000;
  localparam int          LONG_HOLD  = 3000;
  localparam int          IDLE_WAIT  = 60;
  localparam int          ONE_Q16    = 32'sh0001_0000;
  localparam int          MAX_Q16    = 32'sh7FFF_FFFF;
  localparam int          MIN_Q16    = 32'sh8000_0000;
  localparam int unsigned MAX_U32    = 32'hFFFF_FFFF;
  localparam logic        LD         = tbec_pkg::REQ_LOAD;
  localparam logic        CL         = tbec_pkg::REQ_COLLIDE;

  // one collision result as seen on the output stream
  typedef struct {
    int unsigned idx;
    int          u, v, w;
    bit          degen, last;
  } vel_beat_t;

  // one row of the directed table
  typedef struct {
    logic        kind;
    int unsigned ia, ib;
    int          px, py, pz, vu, vv, vw;
    int unsigned vol;
    bit          typed;
    int          ea_u, ea_v, ea_w, eb_u, eb_v, eb_w;
  } dir_row_t;

  logic                           clk_i;
  logic                           rst_ni;
  logic [tbec_pkg::S_TDATA_W-1:0] s_axis_tdata;
  logic [0:0]                     s_axis_tuser;
  logic                           s_axis_tvalid;
  logic                           s_axis_tready;
  logic [tbec_pkg::M_TDATA_W-1:0] m_axis_tdata;
  logic [0:0]                     m_axis_tuser;
  logic                           m_axis_tlast;
  logic                           m_axis_tvalid;
  logic                           m_axis_tready;
  logic                           cfg_we_i;
  logic [31:0]                    cfg_wdata_i;

  // predictor copy of the particle table and density
  int          pos_x[1024], pos_y[1024], pos_z[1024];
  int          vel_u[1024], vel_v[1024], vel_w[1024];
  int unsigned vol_tab[1024];
  bit          loaded[1024];
  int unsigned loaded_list[$];
  bit [31:0]   density;

  vel_beat_t   vel_q[$];
  int          errors;
  int          stall_left;
  bit          hold_req;
  bit          calm;

  two_body_elastic_collision dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  // directed rows: extremes, zero distance, zero mass, same particle
  dir_row_t dir_tab[N_DIRECTED] = '{
    '{LD, 0, 0, 0, 0, 0, ONE_Q16, -ONE_Q16, 0, ONE_Q16, 0, 0, 0, 0, 0, 0, 0},
    '{LD, 1023, 1023, 2 * ONE_Q16, 0, 0, -ONE_Q16, 0, 0, ONE_Q16,
      0, 0, 0, 0, 0, 0, 0},
    '{CL, 0, 0, 0, 0, 0, 0, 0, 0, 0,
      1, ONE_Q16, -ONE_Q16, 0, ONE_Q16, -ONE_Q16, 0},
    '{CL, 0, 1023, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{LD, 5, 0, 0, 0, 0, MAX_Q16, MIN_Q16, 0, MAX_U32, 0, 0, 0, 0, 0, 0, 0},
    '{CL, 5, 5, 0, 0, 0, 0, 0, 0, 0,
      1, MAX_Q16, MIN_Q16, 0, MAX_Q16, MIN_Q16, 0},
    '{LD, 2, 0, MAX_Q16, MAX_Q16, MAX_Q16, MIN_Q16, 7, -3, 0, 0, 0, 0, 0, 0, 0, 0},
    '{LD, 3, 0, MIN_Q16, MIN_Q16, MIN_Q16, 1, 2, 3, 0, 0, 0, 0, 0, 0, 0, 0},
    '{CL, 2, 3, 0, 0, 0, 0, 0, 0, 0, 1, MIN_Q16, 7, -3, 1, 2, 3},
    '{CL, 5, 1023, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{CL, 2, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{LD, 6, 1, MIN_Q16, MAX_Q16, MIN_Q16, MAX_Q16, MAX_Q16, MAX_Q16, ONE_Q16,
      0, 0, 0, 0, 0, 0, 0},
    '{LD, 7, 2, MAX_Q16, MIN_Q16, MAX_Q16, MIN_Q16, MIN_Q16, MIN_Q16, MAX_U32,
      0, 0, 0, 0, 0, 0, 0},
    '{CL, 6, 7, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{CL, 7, 6, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0}
  };

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    repeat (CYC_LIMIT) @(posedge clk_i);
    $display("TEST FAILED");
    $finish;
  end

  // integer square root, bit by bit
  function automatic longint unsigned isqrt(input longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'h4000_0000_0000_0000;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // shift right by 28, round half away from zero
  function automatic longint shr28_round(input longint x);
    longint unsigned m;
    m = (x < 0) ? longint'(-x) : x;
    m = (m + (64'd1 << 27)) >> 28;
    return (x < 0) ? -longint'(m) : longint'(m);
  endfunction

  function automatic int clamp32(input longint x);
    if (x > longint'(MAX_Q16)) return MAX_Q16;
    if (x < longint'(MIN_Q16)) return MIN_Q16;
    return int'(x);
  endfunction

  // field by field compare of two result beats
  function automatic bit beat_match(input vel_beat_t a, input vel_beat_t b);
    return (a.idx == b.idx) && (a.u == b.u) && (a.v == b.v) && (a.w == b.w) &&
           (a.degen == b.degen) && (a.last == b.last);
  endfunction

  // elastic exchange of normal momentum, updates the table copy
  task automatic collide_predict(input int unsigned ia, input int unsigned ib,
                                 output vel_beat_t ra, output vel_beat_t rb);
    longint          va[3], vb[3], d[3], n[3];
    longint unsigned mag[3], mx, sum, r, ma, mb, s, q;
    longint          vna, vnb, diff, wa, wb, da, db;
    bit              degen;
    va[0] = vel_u[ia]; va[1] = vel_v[ia]; va[2] = vel_w[ia];
    vb[0] = vel_u[ib]; vb[1] = vel_v[ib]; vb[2] = vel_w[ib];
    d[0] = longint'(pos_x[ia]) - longint'(pos_x[ib]);
    d[1] = longint'(pos_y[ia]) - longint'(pos_y[ib]);
    d[2] = longint'(pos_z[ia]) - longint'(pos_z[ib]);
    mx = 0;
    for (int i = 0; i < 3; i++) begin
      mag[i] = (d[i] < 0) ? longint'(-d[i]) : d[i];
      if (mag[i] > mx) mx = mag[i];
    end
    ma = 64'(density) * 64'(vol_tab[ia]);
    mb = 64'(density) * 64'(vol_tab[ib]);
    degen = (mx == 0) || (ma == 0 && mb == 0);
    if (!degen) begin
      // normalize the largest magnitude into [2^30, 2^31)
      if (mx >= (64'd1 << 31)) begin
        for (int i = 0; i < 3; i++) mag[i] = mag[i] >> 1;
      end else begin
        while (mx < (64'd1 << 30)) begin
          mx = mx << 1;
          for (int i = 0; i < 3; i++) mag[i] = mag[i] << 1;
        end
      end
      sum = mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2];
      r = isqrt(sum);
      vna = 0;
      vnb = 0;
      for (int i = 0; i < 3; i++) begin
        q = ((mag[i] << 28) + (r >> 1)) / r;
        n[i] = (d[i] < 0) ? -longint'(q) : longint'(q);
        vna += va[i] * n[i];
        vnb += vb[i] * n[i];
      end
      vna = shr28_round(vna);
      vnb = shr28_round(vnb);
      while (((ma | mb) >> 31) != 0) begin
        ma = ma >> 1;
        mb = mb >> 1;
      end
      s = ma + mb;
      wa = longint'((ma << 28) / s);
      wb = longint'((mb << 28) / s);
      diff = vnb - vna;
      da = shr28_round(2 * wb * diff);
      db = shr28_round(-2 * wa * diff);
      for (int i = 0; i < 3; i++) begin
        va[i] = clamp32(va[i] + shr28_round(da * n[i]));
        vb[i] = clamp32(vb[i] + shr28_round(db * n[i]));
      end
      vel_u[ia] = int'(va[0]); vel_v[ia] = int'(va[1]); vel_w[ia] = int'(va[2]);
      vel_u[ib] = int'(vb[0]); vel_v[ib] = int'(vb[1]); vel_w[ib] = int'(vb[2]);
    end
    ra = '{ia, int'(va[0]), int'(va[1]), int'(va[2]), degen, 1'b0};
    rb = '{ib, int'(vb[0]), int'(vb[1]), int'(vb[2]), degen, 1'b1};
  endtask

  // drive one beat after a random gap, then update the predictor on accept
  task automatic send_item(input dir_row_t it);
    int        gap;
    vel_beat_t ra, rb;
    gap = calm ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= it.kind;
    s_axis_tdata  <= {4'b0, it.vol, it.vw, it.vv, it.vu, it.pz, it.py, it.px,
                      it.ib[9:0], it.ia[9:0]};
    do @(posedge clk_i); while (!s_axis_tready);
    if (it.kind == tbec_pkg::REQ_LOAD) begin
      pos_x[it.ia] = it.px; pos_y[it.ia] = it.py; pos_z[it.ia] = it.pz;
      vel_u[it.ia] = it.vu; vel_v[it.ia] = it.vv; vel_w[it.ia] = it.vw;
      vol_tab[it.ia] = it.vol;
      if (!loaded[it.ia]) begin
        loaded[it.ia] = 1'b1;
        loaded_list.push_back(it.ia);
      end
    end else begin
      collide_predict(it.ia, it.ib, ra, rb);
      if (it.typed) begin
        ra = '{it.ia, it.ea_u, it.ea_v, it.ea_w, 1'b1, 1'b0};
        rb = '{it.ib, it.eb_u, it.eb_v, it.eb_w, 1'b1, 1'b1};
      end
      vel_q.push_back(ra);
      vel_q.push_back(rb);
    end
  endtask

  // wait for every collision result, then for the load latency
  task automatic drain;
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (vel_q.size() != 0) @(posedge clk_i);
    repeat (IDLE_WAIT) @(posedge clk_i);
  endtask

  task automatic write_density(input bit [31:0] value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    density = value;
  endtask

  // position or velocity component in one of several ranges
  function automatic int pick_q16(input bit wide);
    int sel;
    sel = $urandom_range(0, 9);
    if (wide || sel == 0) return int'($urandom);
    if (sel < 4) return int'($urandom_range(0, 32'h0000_FFFF)) - 32'sh8000;
    return int'($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000;
  endfunction

  // random item: mostly loads into a small pool and collisions among loaded entries
  function automatic dir_row_t make_item(input int unsigned pool[16]);
    dir_row_t    it;
    int unsigned src;
    bit          wide;
    it = '{default: 0};
    wide = ($urandom_range(0, 9) == 0);
    if (loaded_list.size() > 1 && $urandom_range(0, 99) < 40) begin
      it.kind = tbec_pkg::REQ_COLLIDE;
      it.ia = loaded_list[$urandom_range(0, loaded_list.size() - 1)];
      it.ib = ($urandom_range(0, 19) == 0) ? it.ia
            : loaded_list[$urandom_range(0, loaded_list.size() - 1)];
    end else begin
      it.kind = tbec_pkg::REQ_LOAD;
      it.ia = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023)
            : pool[$urandom_range(0, 15)];
      it.ib = $urandom_range(0, 1023);
      if (loaded_list.size() > 0 && $urandom_range(0, 9) == 0) begin
        // same centre as an existing particle
        src = loaded_list[$urandom_range(0, loaded_list.size() - 1)];
        it.px = pos_x[src]; it.py = pos_y[src]; it.pz = pos_z[src];
      end else begin
        it.px = pick_q16(wide); it.py = pick_q16(wide); it.pz = pick_q16(wide);
      end
      it.vu = pick_q16(wide); it.vv = pick_q16(wide); it.vw = pick_q16(wide);
      case ($urandom_range(0, 9))
        0: begin
          it.vol = 0;
        end
        1: begin
          it.vol = $urandom;
        end
        default: begin
          it.vol = $urandom_range(1, 32'h0010_0000);
        end
      endcase
    end
    return it;
  endfunction

  // output side: random stall after each beat, one long hold on request
  initial begin
    m_axis_tready = 1'b0;
    stall_left    = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // result checker
  always @(posedge clk_i) begin
    vel_beat_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = '{m_axis_tdata[9:0], int'(m_axis_tdata[41:10]), int'(m_axis_tdata[73:42]),
              int'(m_axis_tdata[105:74]), m_axis_tuser[0], m_axis_tlast};
      if (vel_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected beat idx %0d", got.idx);
      end else begin
        want = vel_q.pop_front();
        if (!beat_match(got, want)) begin
          errors++;
          if (errors <= 10) begin
            $display("mismatch exp idx %0d v %h %h %h dg %b l %b",
                     want.idx, want.u, want.v, want.w, want.degen, want.last);
            $display("         got idx %0d v %h %h %h dg %b l %b",
                     got.idx, got.u, got.v, got.w, got.degen, got.last);
          end
        end
      end
      if (hold_req) begin
        hold_req   = 1'b0;
        stall_left = LONG_HOLD;
      end else begin
        stall_left = calm ? 0 : $urandom_range(0, 4);
      end
    end
  end

  // stimulus
  initial begin
    int unsigned pool[16];
    bit [31:0]   phase_density[N_PHASES];
    errors        = 0;
    hold_req      = 1'b0;
    calm          = 1'b0;
    density       = tbec_pkg::DENSITY_RST;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = tbec_pkg::REQ_LOAD;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed part under the reset density
    for (int i = 0; i < N_DIRECTED; i++) send_item(dir_tab[i]);
    drain();

    for (int i = 0; i < 16; i++) pool[i] = $urandom_range(0, 1023);
    phase_density = '{32'd1, MAX_U32, 32'd0, tbec_pkg::DENSITY_RST, $urandom};

    // random part, one density per phase
    for (int p = 0; p < N_PHASES; p++) begin
      write_density(phase_density[p]);
      if (p == 0) hold_req = 1'b1;
      for (int i = 0; i < N_RANDOM / N_PHASES; i++) begin
        if (i % 40 == 0) calm = ($urandom_range(0, 3) == 0);
        send_item(make_item(pool));
      end
      calm = 1'b0;
      drain();
    end

    if (vel_q.size() != 0) errors++;
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
